>>> hdl/bnps_pkg.sv
// Shared types, codes and constants for the budget nearest point search block.
package bnps_pkg;

    localparam int BNPS_MAX_POINTS = 1024;
    localparam int COORD_W         = 30;
    localparam int SQ_W            = 2 * COORD_W;
    localparam int DIST_W          = SQ_W + 1;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] best_x;
        logic [COORD_W-1:0] best_y;
        logic [COORD_W-1:0] best_weight;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
    } t_point;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT,
        ST_OVERFLOW
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic scan_step;
        logic load_query;
        logic load_ovf;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic last;
        logic busy;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/budget_nearest_point_search.sv
// Budget nearest point search: keeps a point store and finds the nearest point under a weight limit.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one beat per item:
// clear the store, append a point, or query. A query returns the stored point
// nearest by squared distance among points whose weight is at most the query
// weight; equal distances go to the earliest loaded point.
// Output channel (o_out_valid / i_out_stall / o_out_data) carries one beat per
// query and one per append dropped because the store is full.
// Clear and append do not stall the input, but an append to a full store
// waits to load its overflow beat. A query scans the store through one memory
// read port, one point per cycle, then drains a three-stage diff/square/compare
// pipeline; the input stays stalled until the query's result is loaded.
// The result sits in an output register; while the receiver stalls it holds,
// and a following result waits for it to be taken before it is loaded.
// Reset empties the store and clears the output valid flag; memory contents
// need no clearing pass, since only entries below the fill count are read.
module budget_nearest_point_search import bnps_pkg::*; #(
    parameter int MAX_POINTS = BNPS_MAX_POINTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd cmd;
    t_sts sts;

    bnps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bnps_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hdl/bnps_ctrl.sv
// Controller state machine: sequences appends, scans and result loads.
module bnps_ctrl import bnps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_kind,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        KIND_APPEND: begin
                            if (i_sts.full) begin
                                n_state = ST_OVERFLOW;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            o_cmd.start = 1'b1;
                            n_state     = i_sts.empty ? ST_DRAIN : ST_SCAN;
                        end
                        default: begin
                            // drop the beat
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_query = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_OVERFLOW: begin
                if (i_sts.out_free) begin
                    o_cmd.load_ovf = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/bnps_dp.sv
// Datapath: point memory, scan pipeline, best-point tracking and output register.
module bnps_dp import bnps_pkg::*; #(
    parameter int MAX_POINTS = BNPS_MAX_POINTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_POINTS);

    t_point mem [MAX_POINTS];

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [COORD_W-1:0] r_qx;
    logic [COORD_W-1:0] r_qy;
    logic [COORD_W-1:0] r_qw;

    // stage 1: memory read data
    logic   r_v1;
    t_point r_rd;
    // stage 2: absolute differences and weight check
    logic               r_v2;
    logic               r_q2;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_dy;
    t_point             r_pt2;
    // stage 3: squares
    logic            r_v3;
    logic            r_q3;
    logic [SQ_W-1:0] r_sx;
    logic [SQ_W-1:0] r_sy;
    t_point          r_pt3;
    // best so far
    logic              r_have;
    logic [DIST_W-1:0] r_best_d;
    t_point            r_best;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [DIST_W-1:0] sum_sq;
    logic [CW-1:0]     idx_inc;
    logic              out_free;

    assign sum_sq   = {1'b0, r_sx} + {1'b0, r_sy};
    assign idx_inc  = r_idx + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.full     = (r_count == FULL_COUNT);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.last     = (idx_inc == r_count);
    assign o_sts.busy     = r_v1 || r_v2 || r_v3;
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem[r_count[AW-1:0]] <= '{x: i_in_data.coord_x, y: i_in_data.coord_y,
                                      w: i_in_data.weight};
        end
        r_rd <= mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= '0;
            r_qx  <= i_in_data.coord_x;
            r_qy  <= i_in_data.coord_y;
            r_qw  <= i_in_data.weight;
        end else if (i_cmd.scan_step) begin
            r_idx <= idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q2  <= (r_rd.w <= r_qw);
        r_dx  <= (r_rd.x >= r_qx) ? (r_rd.x - r_qx) : (r_qx - r_rd.x);
        r_dy  <= (r_rd.y >= r_qy) ? (r_rd.y - r_qy) : (r_qy - r_rd.y);
        r_pt2 <= r_rd;
        r_q3  <= r_q2;
        r_sx  <= r_dx * r_dx;
        r_sy  <= r_dy * r_dy;
        r_pt3 <= r_pt2;
    end

    // strict less-than keeps the earliest point on equal distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.start) begin
            r_have <= 1'b0;
        end else if (r_v3 && r_q3 && (!r_have || sum_sq < r_best_d)) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && r_q3 && (!r_have || sum_sq < r_best_d)) begin
            r_best_d <= sum_sq;
            r_best   <= r_pt3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_query || i_cmd.load_ovf) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ovf) begin
            r_out <= '{found: 1'b0, best_x: '0, best_y: '0, best_weight: '0,
                       overflow: 1'b1};
        end else if (i_cmd.load_query) begin
            r_out.found       <= r_have;
            r_out.best_x      <= r_have ? r_best.x : '0;
            r_out.best_y      <= r_have ? r_best.y : '0;
            r_out.best_weight <= r_have ? r_best.w : '0;
            r_out.overflow    <= 1'b0;
        end
    end

endmodule
